### sv/vca_pkg.sv
// ----------------------------------------------------------------------------
// vca_pkg
// Shared types and codes for the velocity curve and amplitude pipeline.
// ----------------------------------------------------------------------------
package vca_pkg;

   // Driver model selection
   typedef enum logic [1:0] {
      MODEL_V128 = 2'd0,
      MODEL_V133 = 2'd1,
      MODEL_V220 = 2'd2,
      MODEL_V31  = 2'd3
   } vca_model_type;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_VOLUME_MODEL = 2'd0;
   localparam logic [1:0] CSR_CURVE_POINTS = 2'd1;
   localparam logic [1:0] CSR_CURVE_LEVELS = 2'd2;
   localparam logic [1:0] CSR_CURVE_RATES  = 2'd3;

   // Curve segment operations (low three bits of a rate byte)
   localparam logic [2:0] OP_KEEP_LOW   = 3'd0;
   localparam logic [2:0] OP_ADD_STEEP  = 3'd1;
   localparam logic [2:0] OP_ADD_MARGIN = 3'd2;
   localparam logic [2:0] OP_ADD_SHR    = 3'd3;
   localparam logic [2:0] OP_KEEP_HIGH  = 3'd4;
   localparam logic [2:0] OP_SUB_SHR    = 3'd5;
   localparam logic [2:0] OP_SUB_MARGIN = 3'd6;
   localparam logic [2:0] OP_SUB_STEEP  = 3'd7;

   localparam vca_model_type MODEL_RESET = MODEL_V133;

endpackage

### sv/velocity_curve_amplitude.sv
// ----------------------------------------------------------------------------
// velocity_curve_amplitude
// Four-segment velocity curve followed by a selectable driver amplitude model.
// ----------------------------------------------------------------------------
// A request is registered in turn in stages 1, 2, 3 and 4 and then in the
// response register.
// Throughput: one transaction per cycle; five register stages, each carrying a
// valid bit, and the whole pipe holds while the response is stalled.
// Reset: synchronous; clears all valid bits, volume_model to v1.33 and the
// curve registers to zero.
module velocity_curve_amplitude (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [6:0]           req_note_velocity,
   input  logic [7:0]           req_total_level,
   input  logic signed [7:0]    req_volume_bias,
   input  logic [6:0]           req_channel_volume,
   input  logic [6:0]           req_channel_expression,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [6:0]           rsp_curve_level,
   output logic [7:0]           rsp_amplitude,
   // register write port
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata
);

   import vca_pkg::*;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   vca_model_type volume_model_ff;
   logic [23:0]   curve_points_ff;
   logic [23:0]   curve_levels_ff;
   logic [31:0]   curve_rates_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_model_ff <= MODEL_RESET;
         curve_points_ff <= '0;
         curve_levels_ff <= '0;
         curve_rates_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_VOLUME_MODEL: volume_model_ff <= vca_model_type'(csr_wdata[1:0]);
            CSR_CURVE_POINTS: curve_points_ff <= csr_wdata[23:0];
            CSR_CURVE_LEVELS: curve_levels_ff <= csr_wdata[23:0];
            CSR_CURVE_RATES:  curve_rates_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline control: everything moves unless the response is held
   // ------------------------------------------------------------------------
   logic advance;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: segment search, margin above the breakpoint
   // ------------------------------------------------------------------------
   logic [7:0] vel8;
   logic [7:0] point_in, base_in, rate_in, margin_in;

   assign vel8 = {1'b0, req_note_velocity};

   always_comb begin
      point_in = '0;
      base_in  = '0;
      rate_in  = curve_rates_ff[7:0];
      if (vel8 > curve_points_ff[7:0]) begin
         point_in = curve_points_ff[7:0];
         base_in  = curve_levels_ff[7:0];
         rate_in  = curve_rates_ff[15:8];
         if (vel8 > curve_points_ff[15:8]) begin
            point_in = curve_points_ff[15:8];
            base_in  = curve_levels_ff[15:8];
            rate_in  = curve_rates_ff[23:16];
            if (vel8 > curve_points_ff[23:16]) begin
               point_in = curve_points_ff[23:16];
               base_in  = curve_levels_ff[23:16];
               rate_in  = curve_rates_ff[31:24];
            end
         end
      end
      margin_in = vel8 - point_in;
   end

   logic [7:0]        s1_margin_ff, s1_base_ff, s1_rate_ff, s1_tl_ff;
   logic signed [7:0] s1_bias_ff;
   logic [6:0]        s1_vol_ff, s1_expr_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_margin_ff <= margin_in;
         s1_base_ff   <= base_in;
         s1_rate_ff   <= rate_in;
         s1_tl_ff     <= req_total_level;
         s1_bias_ff   <= req_volume_bias;
         s1_vol_ff    <= req_channel_volume;
         s1_expr_ff   <= req_channel_expression;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: segment operation, 8-bit wrap and overflow fold
   // ------------------------------------------------------------------------
   logic [3:0]  shift;
   logic [10:0] m12;
   logic [25:0] m12_shl;
   logic [22:0] m_shl;
   logic [7:0]  steep, m_shr, conv;
   logic [6:0]  level_in;

   always_comb begin
      shift   = s1_rate_ff[7:4];
      // margin x12 as two shifted copies; the >>3 picks bits 10..3
      m12     = {1'b0, s1_margin_ff[6:0], 3'b000} + {2'b00, s1_margin_ff[6:0], 2'b00};
      m12_shl = {15'd0, m12} << shift;
      m_shl   = {15'd0, s1_margin_ff} << shift;
      steep   = s1_rate_ff[3] ? m12_shl[10:3] : m_shl[7:0];
      m_shr   = s1_margin_ff >> shift;
      case (s1_rate_ff[2:0])
         OP_ADD_STEEP:  conv = s1_base_ff + steep;
         OP_ADD_MARGIN: conv = s1_base_ff + s1_margin_ff;
         OP_ADD_SHR:    conv = s1_base_ff + m_shr;
         OP_SUB_SHR:    conv = s1_base_ff - m_shr;
         OP_SUB_MARGIN: conv = s1_base_ff - s1_margin_ff;
         OP_SUB_STEEP:  conv = s1_base_ff - steep;
         default:       conv = s1_base_ff;
      endcase
      // bit 7 set: fold to 0 or full scale by bit 6
      if (conv[7])
         level_in = conv[6] ? 7'd0 : 7'h7f;
      else
         level_in = conv[6:0];
   end

   logic [6:0]        s2_level_ff;
   logic [7:0]        s2_tl_ff;
   logic signed [7:0] s2_bias_ff;
   logic [6:0]        s2_vol_ff, s2_expr_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_level_ff <= level_in;
         s2_tl_ff    <= s1_tl_ff;
         s2_bias_ff  <= s1_bias_ff;
         s2_vol_ff   <= s1_vol_ff;
         s2_expr_ff  <= s1_expr_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: velocity scale and controller products
   // ------------------------------------------------------------------------
   logic signed [9:0] rl_sum;
   logic [7:0]        rl;
   logic [7:0]        vx;
   logic [8:0]        vy;
   logic [16:0]       pv;
   logic [7:0]        ca, cb;
   logic [15:0]       pc;

   always_comb begin
      // v2.20 release level: 255 - tl + bias, clamped
      rl_sum = $signed({2'b00, ~s2_tl_ff}) + 10'(s2_bias_ff);
      if (rl_sum < 0)
         rl = 8'd0;
      else if (rl_sum > 10'sd255)
         rl = 8'hff;
      else
         rl = rl_sum[7:0];
      case (volume_model_ff)
         MODEL_V128: begin
            vx = {1'b0, s2_level_ff};
            vy = {1'b0, ~s2_tl_ff};
         end
         MODEL_V220: begin
            vx = (s2_level_ff == 7'd0) ? 8'd1 : {1'b0, s2_level_ff};
            vy = {1'b0, rl};
         end
         default: begin
            vx = {1'b0, s2_level_ff} + 8'd1;
            vy = 9'd256 - {1'b0, s2_tl_ff};
         end
      endcase
      if (volume_model_ff == MODEL_V31) begin
         ca = {1'b0, s2_vol_ff} + 8'd1;
         cb = {1'b0, s2_expr_ff} + 8'd1;
      end else begin
         ca = {1'b0, s2_vol_ff};
         cb = {1'b0, s2_expr_ff};
      end
      pv = vx * vy;
      pc = ca * cb;
   end

   logic [6:0]        s3_level_ff;
   logic [15:0]       s3_pv_ff;
   logic [14:0]       s3_pc_ff;
   logic signed [7:0] s3_bias_ff;
   logic [6:0]        s3_vol_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_level_ff <= s2_level_ff;
         s3_pv_ff    <= pv[15:0];
         s3_pc_ff    <= pc[14:0];
         s3_bias_ff  <= s2_bias_ff;
         s3_vol_ff   <= s2_vol_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: combined product
   // ------------------------------------------------------------------------
   logic [15:0] pv_m1, ma;
   logic [14:0] pc_m1;
   logic [7:0]  mb;
   logic [23:0] prod_in;

   always_comb begin
      pv_m1 = s3_pv_ff - 16'd1;
      pc_m1 = s3_pc_ff - 15'd1;
      case (volume_model_ff)
         MODEL_V128: begin
            ma = s3_pv_ff;
            mb = {1'b0, s3_vol_ff};
         end
         MODEL_V133: begin
            ma = s3_pv_ff;
            mb = {1'b0, s3_vol_ff} + 8'd1;
         end
         MODEL_V220: begin
            ma = {8'd0, s3_pv_ff[15:8]};
            mb = s3_pc_ff[14:7];
         end
         default: begin
            ma = {8'd0, pv_m1[15:8]} + 16'd1;
            mb = pc_m1[14:7] + 8'd1;
         end
      endcase
      prod_in = ma * mb;
   end

   logic [6:0]        s4_level_ff;
   logic [23:0]       s4_prod_ff;
   logic signed [7:0] s4_bias_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_level_ff <= s3_level_ff;
         s4_prod_ff  <= prod_in;
         s4_bias_ff  <= s3_bias_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 5: model scaling, bias (not for v2.20) and clamp into the response register
   // ------------------------------------------------------------------------
   logic [25:0]        p4_m1;
   logic [23:0]        p_m1;
   logic [9:0]         amp_raw;
   logic signed [10:0] amp_sum;
   logic [7:0]         amp_in;

   always_comb begin
      p4_m1 = {s4_prod_ff, 2'b00} - 26'd1;
      p_m1  = s4_prod_ff - 24'd1;
      case (volume_model_ff)
         MODEL_V128: amp_raw = s4_prod_ff[23:14];
         MODEL_V133: amp_raw = p4_m1[25:16];
         MODEL_V220: amp_raw = s4_prod_ff[15:6];
         default:    amp_raw = p_m1[15:6];
      endcase
      if (volume_model_ff == MODEL_V220)
         amp_sum = $signed({1'b0, amp_raw});
      else
         amp_sum = $signed({1'b0, amp_raw}) + 11'(s4_bias_ff);
      if (amp_sum < 0)
         amp_in = 8'd0;
      else if (amp_sum > 11'sd255)
         amp_in = 8'hff;
      else
         amp_in = amp_sum[7:0];
   end

   logic [6:0] rsp_level_ff;
   logic [7:0] rsp_amp_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_level_ff <= s4_level_ff;
         rsp_amp_ff   <= amp_in;
      end
   end

   assign rsp_curve_level = rsp_level_ff;
   assign rsp_amplitude   = rsp_amp_ff;

endmodule
